### design/lte_pkg.sv
// Shared types and constants of the lease table with expiry.
`default_nettype none
package lte_pkg;

  localparam int KIND_W    = 3;
  localparam int CLIENT_W  = 16;
  localparam int RES_W     = 4;
  localparam int NOW_W     = 40;
  localparam int TTL_W     = 32;
  localparam int DL_W      = NOW_W + 1;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [TTL_W-1:0] MIN_TTL_RST = TTL_W'(1000);
  localparam logic [TTL_W-1:0] MAX_TTL_RST = TTL_W'(30000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TTL = 1'b0,
    CFG_MAX_TTL = 1'b1
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 3'd0,
    KIND_RENEW   = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_OWNS    = 3'd3,
    KIND_CURRENT = 3'd4,
    KIND_SWEEP   = 3'd5
  } kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_LOOK,
    S_EVAL,
    S_CLAMP_HI,
    S_CLAMP_LO,
    S_ADD,
    S_REMAIN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### design/lte_ifs.sv
// Request and result channel interfaces of the lease table.
`default_nettype none
interface lte_in_if;
  import lte_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CLIENT_W-1:0] client;
  logic [RES_W-1:0]    resource;
  logic [NOW_W-1:0]    now_ms;
  logic [TTL_W-1:0]    ttl_ms;

  modport source (output valid, kind, client, resource, now_ms, ttl_ms, input ready);
  modport sink   (input valid, kind, client, resource, now_ms, ttl_ms, output ready);
endinterface

interface lte_out_if;
  import lte_pkg::*;
  logic                valid;
  logic                ready;
  logic                ok;
  logic [CLIENT_W-1:0] holder;
  logic [TTL_W-1:0]    remaining_ms;
  logic [CNT_W-1:0]    cleared;

  modport source (output valid, ok, holder, remaining_ms, cleared, input ready);
  modport sink   (input valid, ok, holder, remaining_ms, cleared, output ready);
endinterface
`default_nettype wire

### design/lte_alu.sv
// Shared add/subtract unit used for expiry compares, TTL clamping, deadlines and remaining time.
`default_nettype none
module lte_alu (
  input  logic [lte_pkg::DL_W-1:0] a,
  input  logic [lte_pkg::DL_W-1:0] b,
  input  lte_pkg::alu_op_t         op,
  output logic [lte_pkg::DL_W:0]   res
);
  import lte_pkg::*;

  // The top bit is the carry for an add and the borrow (a < b) for a subtract.
  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default: res = '0;
    endcase
  end
endmodule
`default_nettype wire

### design/lease_table_with_expiry.sv
// Top level of the lease table with expiry: sequencer, lease store and result register.
`default_nettype none
// The block holds one exclusive lease per resource (held bit, owner, deadline) and
// answers one result for every request. Acquire, renew, owns, current and sweep
// first walk every entry of the table and drop leases whose deadline is at or
// before now_ms; this walk reads one entry per cycle from the owner/deadline
// memory. After the walk a sweep goes straight to the result; owns looks up and
// evaluates its entry, current adds the remaining-time step, and acquire or renew
// add the max and min TTL clamps and the deadline add. Release skips the walk and
// only looks up and evaluates its entry, and a request of an unknown kind goes
// straight to the result. The sequencer is back in idle at the edge that loads
// the result, so the next request is accepted only after that edge; a full
// result register that the consumer does not take holds the sequencer in its
// last state. The single read port of the memory and the single shared
// add/subtract unit make these steps run one after another. A new request is taken
// once the sequencer is back in idle, even while the previous result is still
// waiting on the result channel. Configuration writes are meant only while no
// request is in flight; the TTL bounds are applied as max first, then min.
module lease_table_with_expiry #(
  parameter int RESOURCES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lte_in_if.sink                         in_ch,
  lte_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lte_pkg::TTL_W-1:0]      cfg_wdata
);
  import lte_pkg::*;

  localparam int IW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int CW = $clog2(RESOURCES + 1);

  // Configuration registers.
  logic [TTL_W-1:0] min_ttl_r;
  logic [TTL_W-1:0] max_ttl_r;

  // Latched request.
  logic [KIND_W-1:0]   req_kind_r;
  logic [CLIENT_W-1:0] req_client_r;
  logic [RES_W-1:0]    req_res_r;
  logic [NOW_W-1:0]    req_now_r;
  logic [TTL_W-1:0]    req_ttl_r;

  // Sequencer.
  state_t state_r, state_nxt;
  logic [CW-1:0] widx_r;
  logic          pv_r;
  logic [IW-1:0] pj_r;
  logic [CNT_W-1:0] cnt_r;
  logic [TTL_W-1:0] t_r;
  logic             ok_r;
  logic [CLIENT_W-1:0] holder_r;
  logic [TTL_W-1:0]    rem_r;

  // Lease store: held bits in flops, owner and deadline in a memory.
  logic [RESOURCES-1:0] held_r;
  logic [CLIENT_W-1:0]  owner_mem [RESOURCES];
  logic [DL_W-1:0]      dl_mem [RESOURCES];
  logic [CLIENT_W-1:0]  owner_q_r;
  logic [DL_W-1:0]      dl_q_r;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic                 mem_we;

  // Result register.
  logic                out_valid_r;
  logic                out_ok_r;
  logic [CLIENT_W-1:0] out_holder_r;
  logic [TTL_W-1:0]    out_rem_r;
  logic [CNT_W-1:0]    out_cleared_r;

  // Shared arithmetic unit.
  logic [DL_W-1:0] alu_a, alu_b;
  alu_op_t         alu_op;
  logic [DL_W:0]   alu_res;
  logic            alu_borrow;

  logic          in_acc;
  logic          out_load;
  logic          res_ok;
  logic [IW-1:0] idx;
  logic          held_sel;
  logic          match;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign alu_borrow = alu_res[DL_W];

  // An index at or above RESOURCES addresses nothing and fails all but a sweep.
  assign res_ok   = (int'(req_res_r) < RESOURCES);
  assign idx      = IW'(req_res_r);
  assign held_sel = res_ok ? held_r[idx] : 1'b0;
  assign match    = held_sel && (owner_q_r == req_client_r);

  lte_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  // Operand selection for the shared unit, one use per sequencer state.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_SUB;
    unique case (state_r)
      S_SWEEP: begin
        // now - deadline: no borrow means the lease has run out.
        alu_a = {1'b0, req_now_r};
        alu_b = dl_q_r;
      end
      S_CLAMP_HI: begin
        alu_a = DL_W'(max_ttl_r);
        alu_b = DL_W'(req_ttl_r);
      end
      S_CLAMP_LO: begin
        alu_a = DL_W'(t_r);
        alu_b = DL_W'(min_ttl_r);
      end
      S_ADD: begin
        alu_a  = {1'b0, req_now_r};
        alu_b  = DL_W'(t_r);
        alu_op = ALU_ADD;
      end
      S_REMAIN: begin
        alu_a = dl_q_r;
        alu_b = {1'b0, req_now_r};
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind) inside
            KIND_ACQUIRE, KIND_RENEW, KIND_OWNS, KIND_CURRENT, KIND_SWEEP:
              state_nxt = S_SWEEP;
            KIND_RELEASE: state_nxt = S_LOOK;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        if (widx_r == CW'(RESOURCES)) begin
          state_nxt = (req_kind_r == KIND_SWEEP) ? S_DONE : S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_EVAL;
      S_EVAL: begin
        case (req_kind_r) inside
          KIND_ACQUIRE, KIND_RENEW: state_nxt = S_CLAMP_HI;
          KIND_CURRENT:             state_nxt = S_REMAIN;
          default:                  state_nxt = S_DONE;
        endcase
      end
      S_CLAMP_HI: state_nxt = S_CLAMP_LO;
      S_CLAMP_LO: state_nxt = S_ADD;
      S_ADD:      state_nxt = S_DONE;
      S_REMAIN:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ttl_r <= MIN_TTL_RST;
      max_ttl_r <= MAX_TTL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_TTL: min_ttl_r <= cfg_wdata;
        CFG_MAX_TTL: max_ttl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Memory access: the walk reads each entry in turn, and a request that looks up its
  // resource reads the addressed entry once. A granted acquire or renew writes owner and deadline together.
  assign mem_re    = ((state_r == S_SWEEP) && (widx_r < CW'(RESOURCES))) ||
                     (state_r == S_LOOK);
  assign mem_raddr = (state_r == S_SWEEP) ? IW'(widx_r) : idx;
  assign mem_we    = (state_r == S_ADD) && ok_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[idx] <= req_client_r;
      dl_mem[idx]    <= alu_res[DL_W-1:0];
    end
    if (mem_re) begin
      owner_q_r <= owner_mem[mem_raddr];
      dl_q_r    <= dl_mem[mem_raddr];
    end
  end

  // Held bits: set by a granted acquire or renew; cleared by reset, by the expiry walk and by release.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      if ((state_r == S_SWEEP) && pv_r && held_r[pj_r] && !alu_borrow) begin
        held_r[pj_r] <= 1'b0;
      end
      if ((state_r == S_EVAL) && (req_kind_r == KIND_RELEASE) && match) begin
        held_r[idx] <= 1'b0;
      end
      if (mem_we) begin
        held_r[idx] <= 1'b1;
      end
    end
  end

  // Walk control: the read of entry j is issued in the cycle before its compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      pv_r   <= 1'b0;
      cnt_r  <= '0;
    end else if (in_acc) begin
      widx_r <= '0;
      pv_r   <= 1'b0;
      cnt_r  <= '0;
    end else if (state_r == S_SWEEP) begin
      pv_r <= (widx_r < CW'(RESOURCES));
      pj_r <= IW'(widx_r);
      if (widx_r < CW'(RESOURCES)) begin
        widx_r <= widx_r + CW'(1);
      end
      if (pv_r && held_r[pj_r] && !alu_borrow && (cnt_r != '1)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Request latch and per-request results.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_kind_r   <= in_ch.kind;
      req_client_r <= in_ch.client;
      req_res_r    <= in_ch.resource;
      req_now_r    <= in_ch.now_ms;
      req_ttl_r    <= in_ch.ttl_ms;
      ok_r         <= 1'b0;
      holder_r     <= '0;
      rem_r        <= '0;
    end else begin
      unique case (state_r)
        S_SWEEP: begin
          if (req_kind_r == KIND_SWEEP) begin
            ok_r <= 1'b1;
          end
        end
        S_EVAL: begin
          case (req_kind_r)
            KIND_ACQUIRE: ok_r <= res_ok && (!held_sel || (owner_q_r == req_client_r));
            KIND_CURRENT: ok_r <= held_sel;
            default:      ok_r <= match;
          endcase
        end
        S_CLAMP_HI: t_r <= alu_borrow ? max_ttl_r : req_ttl_r;
        S_CLAMP_LO: begin
          if (alu_borrow) begin
            t_r <= min_ttl_r;
          end
        end
        S_REMAIN: begin
          if (ok_r) begin
            holder_r <= owner_q_r;
            rem_r    <= (|alu_res[DL_W-1:TTL_W]) ? '1 : alu_res[TTL_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: holds a finished result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r      <= ok_r;
      out_holder_r  <= holder_r;
      out_rem_r     <= rem_r;
      out_cleared_r <= (req_kind_r == KIND_SWEEP) ? cnt_r : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.holder       = out_holder_r;
  assign out_ch.remaining_ms = out_rem_r;
  assign out_ch.cleared      = out_cleared_r;

endmodule
`default_nettype wire

### design/lte_checker.sv
// Port-level assertions for the lease table and their binding to the top level.
`default_nettype none
module lte_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [lte_pkg::CLIENT_W-1:0]  out_holder,
  input logic [lte_pkg::TTL_W-1:0]     out_remaining_ms,
  input logic [lte_pkg::CNT_W-1:0]     out_cleared
);

  // A result waiting on a stalled consumer is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // The sequencer leaves idle on accepting any request, so it is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in work");

  // Only a sweep reports cleared entries, and a sweep always succeeds.
  a_cleared_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cleared != '0) |-> out_ok && (out_remaining_ms == '0))
    else $error("cleared count without a successful sweep");

  // Holder and remaining time are only filled in by a successful current query.
  a_current_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_holder != '0) || (out_remaining_ms != '0)) |->
      out_ok && (out_cleared == '0))
    else $error("lease details on a failed request");

endmodule

bind lease_table_with_expiry lte_checker u_lte_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_ok           (out_ch.ok),
  .out_holder       (out_ch.holder),
  .out_remaining_ms (out_ch.remaining_ms),
  .out_cleared      (out_ch.cleared)
);
`default_nettype wire
